@@ design/ofd_pkg.sv @@
// Shared types, constants and the byte-wide CRC-32 update for the frame deframer.
// No dependencies.
`timescale 1ns / 1ps

package ofd_pkg;

    localparam int HEADER_BYTES = 15;
    localparam int CRC_BYTES    = 4;
    localparam int FRAME_MIN    = HEADER_BYTES + CRC_BYTES;

    localparam logic [31:0] CRC_INIT  = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [8:0]  COUNT_MAX = 9'h1FF;

    // header offsets
    localparam logic [8:0] POS_VERSION  = 9'd4;
    localparam logic [8:0] POS_KIND     = 9'd5;
    localparam logic [8:0] POS_SEQ_LO   = 9'd10;
    localparam logic [8:0] POS_LEN      = 9'd14;
    localparam logic [8:0] POS_PAYLOAD  = 9'(HEADER_BYTES);

    // configuration register indexes
    localparam logic [7:0] CFG_TYPE_MIN    = 8'd0;
    localparam logic [7:0] CFG_TYPE_MAX    = 8'd1;
    localparam logic [7:0] CFG_PROTO_VER   = 8'd2;
    localparam logic [7:0] CFG_MAX_PAYLOAD = 8'd3;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_LEN = 2'd1,
        ST_HDR = 2'd2,
        ST_CRC = 2'd3
    } t_status;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic        done_res;
        t_status     status;
        logic [7:0]  frame_kind;
        logic [31:0] session_word;
        logic [31:0] sequence_word;
        logic [7:0]  payload_count;
    } t_result;

    // "DFRO"
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] m;
        case (idx)
            2'd0:    m = 8'h44;
            2'd1:    m = 8'h46;
            2'd2:    m = 8'h52;
            default: m = 8'h4F;
        endcase
        return m;
    endfunction

    // reflected CRC-32, one byte, LSB first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ design/ofd_out_reg.sv @@
// Result register with valid/stall handshake for the frame deframer.
// Depends on ofd_pkg (t_result).
`timescale 1ns / 1ps

module ofd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ofd_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_valid,
    output logic             o_full,
    output ofd_pkg::t_result o_res
);
    import ofd_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_res;

    always_comb begin
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_stall) begin
            n_valid = r_valid;
        end else begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    // held word still waiting on the far side
    assign o_full  = r_valid & i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ design/ota_frame_deframer_crc32_top.sv @@
// Top level of the update-frame deframer with CRC-32 check.
// Depends on ofd_pkg and ofd_out_reg.
`timescale 1ns / 1ps

// Takes one frame byte per accepted word and returns exactly one result word for
// each, held in an output register until taken; a new byte is accepted every
// cycle unless that register holds a word the downstream side is stalling. The
// rate of one byte per cycle is set by the byte-wide CRC-32 update, header
// capture and verdict logic, all of which sit between the frame state registers
// and the output register. Payload bytes come out flagged with their index; the
// word for the byte marked last carries the status and the header fields, after
// which frame state returns to its reset values. Configuration writes are always
// ready and take effect from the next byte on.

module ota_frame_deframer_crc32_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_payload_valid,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_payload_index,
    output logic        o_done_res,
    output logic [1:0]  o_status,
    output logic [7:0]  o_frame_kind,
    output logic [31:0] o_session_word,
    output logic [31:0] o_sequence_word,
    output logic [7:0]  o_payload_count,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import ofd_pkg::*;

    logic [7:0] r_type_min, r_type_max, r_proto_ver, r_max_payload;

    logic [8:0]  r_count,   n_count;
    logic [31:0] r_crc,     n_crc;
    logic        r_hdr_ok,  n_hdr_ok;
    logic [7:0]  r_kind,    n_kind;
    logic [31:0] r_session, n_session;
    logic [31:0] r_seq,     n_seq;
    logic [7:0]  r_len,     n_len;
    logic [31:0] r_tail,    n_tail;

    logic    accept;
    logic    out_full;
    t_result res;
    t_result out_res;

    logic [8:0] pay_end;
    logic [9:0] total;
    t_status    status;

    assign accept      = i_valid & ~out_full;
    assign o_stall     = out_full;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type_min    <= 8'd0;
            r_type_max    <= 8'd255;
            r_proto_ver   <= 8'd1;
            r_max_payload <= 8'd255;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TYPE_MIN:    r_type_min    <= i_cfg_data;
                CFG_TYPE_MAX:    r_type_max    <= i_cfg_data;
                CFG_PROTO_VER:   r_proto_ver   <= i_cfg_data;
                CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_hdr_ok  = r_hdr_ok;
        n_kind    = r_kind;
        n_session = r_session;
        n_seq     = r_seq;
        n_len     = r_len;

        if (r_count < POS_VERSION) begin
            if (i_data_byte != magic_byte(r_count[1:0])) n_hdr_ok = 1'b0;
        end else if (r_count == POS_VERSION) begin
            if (i_data_byte != r_proto_ver) n_hdr_ok = 1'b0;
        end else if (r_count == POS_KIND) begin
            n_kind = i_data_byte;
            if (i_data_byte < r_type_min || i_data_byte > r_type_max) n_hdr_ok = 1'b0;
        end else if (r_count < POS_SEQ_LO) begin
            n_session = {r_session[23:0], i_data_byte};
        end else if (r_count < POS_LEN) begin
            n_seq = {r_seq[23:0], i_data_byte};
        end else if (r_count == POS_LEN) begin
            n_len = i_data_byte;
        end

        pay_end = {1'b0, n_len} + POS_PAYLOAD;
        n_crc   = (r_count < pay_end) ? crc_byte(r_crc, i_data_byte) : r_crc;
        n_tail  = {r_tail[23:0], i_data_byte};

        total = {1'b0, r_count} + 10'd1;
        if (total < 10'(FRAME_MIN) || total > (10'(FRAME_MIN) + {2'd0, r_max_payload})) begin
            status = ST_LEN;
        end else if (!n_hdr_ok) begin
            status = ST_HDR;
        end else if (n_len > r_max_payload) begin
            status = ST_LEN;
        end else if (total != (10'(FRAME_MIN) + {2'd0, n_len})) begin
            status = ST_LEN;
        end else if ((n_crc ^ CRC_INIT) != n_tail) begin
            status = ST_CRC;
        end else begin
            status = ST_OK;
        end

        res = '0;
        if (r_count >= POS_PAYLOAD && r_count < pay_end) begin
            res.payload_valid = 1'b1;
            res.payload_byte  = i_data_byte;
            res.payload_index = 8'(r_count - POS_PAYLOAD);
        end
        if (i_last) begin
            res.done_res      = 1'b1;
            res.status        = status;
            res.frame_kind    = n_kind;
            res.session_word  = n_session;
            res.sequence_word = n_seq;
            res.payload_count = n_len;
        end

        if (i_last) begin
            n_count = '0;
        end else if (r_count < COUNT_MAX) begin
            n_count = r_count + 9'd1;
        end else begin
            n_count = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last)) begin
            r_count   <= '0;
            r_crc     <= CRC_INIT;
            r_hdr_ok  <= 1'b1;
            r_kind    <= '0;
            r_session <= '0;
            r_seq     <= '0;
            r_len     <= '0;
            r_tail    <= '0;
        end else if (accept) begin
            r_count   <= n_count;
            r_crc     <= n_crc;
            r_hdr_ok  <= n_hdr_ok;
            r_kind    <= n_kind;
            r_session <= n_session;
            r_seq     <= n_seq;
            r_len     <= n_len;
            r_tail    <= n_tail;
        end
    end

    ofd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_res   (res),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_full  (out_full),
        .o_res   (out_res)
    );

    assign o_payload_valid = out_res.payload_valid;
    assign o_payload_byte  = out_res.payload_byte;
    assign o_payload_index = out_res.payload_index;
    assign o_done_res      = out_res.done_res;
    assign o_status        = out_res.status;
    assign o_frame_kind    = out_res.frame_kind;
    assign o_session_word  = out_res.session_word;
    assign o_sequence_word = out_res.sequence_word;
    assign o_payload_count = out_res.payload_count;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Testbench for the update-frame deframer: a directed byte table, hand-built frames and
// random framed traffic, all checked word by word. Depends on ofd_pkg and the top level.

module testbench;
    import ofd_pkg::*;

    localparam int          HOLD_CYCLES  = 150;
    localparam int          RANDOM_ITEMS = 150;
    localparam logic [31:0] MAGIC_WORD   = "DFRO";
    // short frame with a bad first magic byte, trailing bytes stand in for the CRC
    localparam logic [151:0] BAD_MAGIC_FRAME =
        152'h00_46_52_4F_01_07_DE_AD_BE_EF_01_02_03_04_00_FF_FF_FF_FF;

    typedef enum int { FF_NONE, FF_CRC, FF_MAGIC, FF_TRUNC, FF_EXTRA } t_fault;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        t_result    want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_payload_valid;
    logic [7:0]  o_payload_byte;
    logic [7:0]  o_payload_index;
    logic        o_done_res;
    logic [1:0]  o_status;
    logic [7:0]  o_frame_kind;
    logic [31:0] o_session_word;
    logic [31:0] o_sequence_word;
    logic [7:0]  o_payload_count;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = 8'h00;
    logic [7:0]  i_cfg_data = 8'h00;

    ota_frame_deframer_crc32_top u_dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state and its copy of the registers
    logic [8:0]  frame_pos;
    logic [31:0] crc_run;
    logic        hdr_ok;
    logic [7:0]  cap_kind;
    logic [31:0] cap_session;
    logic [31:0] cap_sequence;
    logic [7:0]  cap_len;
    logic [31:0] tail_bytes;
    logic [7:0]  lim_type_lo, lim_type_hi, want_version, pay_limit;

    t_result     word_q[$];
    logic [7:0]  frame_q[$];
    int          errors = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    logic        idle_on = 1'b1;
    int          hold_ask = 0;

    function automatic logic [31:0] crc32_next(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        logic        fb;
        r = c;
        for (int k = 0; k < 8; k++) begin
            fb = r[0] ^ d[k];
            r = {1'b0, r[31:1]} ^ (fb ? CRC_POLY : 32'd0);
        end
        return r;
    endfunction

    task automatic clear_frame_state();
        frame_pos    = '0;
        crc_run      = CRC_INIT;
        hdr_ok       = 1'b1;
        cap_kind     = '0;
        cap_session  = '0;
        cap_sequence = '0;
        cap_len      = '0;
        tail_bytes   = '0;
    endtask

    task automatic predict_word(input logic [7:0] b, input logic l, output t_result r);
        int pos;
        int total;
        pos = int'(frame_pos);
        r = '0;
        if (pos < 4) begin
            if (b != MAGIC_WORD[8*(3-pos) +: 8]) hdr_ok = 1'b0;
        end else if (pos == 4) begin
            if (b != want_version) hdr_ok = 1'b0;
        end else if (pos == 5) begin
            cap_kind = b;
            if (b < lim_type_lo || b > lim_type_hi) hdr_ok = 1'b0;
        end else if (pos < 10) begin
            cap_session = {cap_session[23:0], b};
        end else if (pos < 14) begin
            cap_sequence = {cap_sequence[23:0], b};
        end else if (pos == 14) begin
            cap_len = b;
        end
        // CRC covers header and declared payload only
        if (pos < HEADER_BYTES + int'(cap_len)) crc_run = crc32_next(crc_run, b);
        if (pos >= HEADER_BYTES && pos < HEADER_BYTES + int'(cap_len)) begin
            r.payload_valid = 1'b1;
            r.payload_byte  = b;
            r.payload_index = 8'(pos - HEADER_BYTES);
        end
        tail_bytes = {tail_bytes[23:0], b};
        if (l) begin
            total = pos + 1;
            if (total < FRAME_MIN || total > FRAME_MIN + int'(pay_limit)) r.status = ST_LEN;
            else if (!hdr_ok) r.status = ST_HDR;
            else if (cap_len > pay_limit) r.status = ST_LEN;
            else if (total != FRAME_MIN + int'(cap_len)) r.status = ST_LEN;
            else if ((crc_run ^ CRC_INIT) != tail_bytes) r.status = ST_CRC;
            else r.status = ST_OK;
            r.done_res      = 1'b1;
            r.frame_kind    = cap_kind;
            r.session_word  = cap_session;
            r.sequence_word = cap_sequence;
            r.payload_count = cap_len;
            clear_frame_state();
        end else if (frame_pos != COUNT_MAX) begin
            frame_pos = frame_pos + 9'd1;
        end
    endtask

    // offer one byte, wait for the handshake, then maybe open an idle gap
    task automatic push_byte(input logic [7:0] b, input logic l, input logic typed,
                             input t_result typed_want);
        t_result pred;
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last      <= l;
        do @(posedge i_clk); while (o_stall);
        predict_word(b, l, pred);
        word_q.push_back(typed ? typed_want : pred);
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(1, 16);
            if (idle_on && $urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
            end
        end
    endtask

    task automatic cfg_write(input logic [7:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_TYPE_MIN:    lim_type_lo  = val;
            CFG_TYPE_MAX:    lim_type_hi  = val;
            CFG_PROTO_VER:   want_version = val;
            CFG_MAX_PAYLOAD: pay_limit    = val;
            default: ;
        endcase
    endtask

    // registers change only once the block has drained
    task automatic set_config(input logic [7:0] tmin, input logic [7:0] tmax,
                              input logic [7:0] ver, input logic [7:0] maxp,
                              input logic junk);
        i_valid <= 1'b0;
        while (word_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (junk) cfg_write(8'hFF, 8'($urandom));   // unmapped index, no effect
        cfg_write(CFG_TYPE_MIN, tmin);
        cfg_write(CFG_TYPE_MAX, tmax);
        cfg_write(CFG_PROTO_VER, ver);
        cfg_write(CFG_MAX_PAYLOAD, maxp);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic make_frame(input logic [7:0] ver, input logic [7:0] kind,
                              input logic [7:0] len_field, input int n_pay,
                              input t_fault fault);
        logic [31:0] crc, sess, seq;
        int k;
        sess = $urandom;
        seq  = $urandom;
        frame_q.delete();
        for (k = 0; k < 4; k++) frame_q.push_back(MAGIC_WORD[8*(3-k) +: 8]);
        frame_q.push_back(ver);
        frame_q.push_back(kind);
        for (k = 3; k >= 0; k--) frame_q.push_back(sess[8*k +: 8]);
        for (k = 3; k >= 0; k--) frame_q.push_back(seq[8*k +: 8]);
        frame_q.push_back(len_field);
        for (k = 0; k < n_pay; k++) frame_q.push_back(8'($urandom));
        crc = CRC_INIT;
        foreach (frame_q[j]) crc = crc32_next(crc, frame_q[j]);
        crc = ~crc;
        for (k = 3; k >= 0; k--) frame_q.push_back(crc[8*k +: 8]);
        case (fault)
            FF_CRC: begin
                k = $urandom_range(frame_q.size() - 4, frame_q.size() - 1);
                frame_q[k] = frame_q[k] ^ 8'(1 << $urandom_range(0, 7));
            end
            FF_MAGIC: begin
                k = $urandom_range(0, 3);
                frame_q[k] = frame_q[k] ^ 8'($urandom_range(1, 255));
            end
            FF_TRUNC: repeat ($urandom_range(1, frame_q.size() - 1)) void'(frame_q.pop_back());
            FF_EXTRA: repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
            default: ;
        endcase
    endtask

    task automatic send_frame();
        foreach (frame_q[j]) push_byte(frame_q[j], j == frame_q.size() - 1, 1'b0, '0);
    endtask

    task automatic random_frame();
        logic [7:0] kind, ver, len;
        int sel, n_pay;
        t_fault fault;
        sel   = $urandom_range(0, 99);
        ver   = want_version;
        kind  = (lim_type_lo <= lim_type_hi) ? 8'($urandom_range(lim_type_lo, lim_type_hi))
                                             : 8'($urandom);
        len   = ($urandom_range(0, 19) == 0) ? pay_limit
                : 8'($urandom_range(0, (pay_limit < 12) ? pay_limit : 12));
        n_pay = int'(len);
        fault = FF_NONE;
        if (sel < 8) fault = FF_CRC;
        else if (sel < 14) fault = FF_MAGIC;
        else if (sel < 18) fault = FF_TRUNC;
        else if (sel < 22) fault = FF_EXTRA;
        else if (sel < 25) ver = ver ^ 8'($urandom_range(1, 255));
        else if (sel < 28) kind = 8'($urandom);
        else if (sel < 30) n_pay = int'(len) + 1;
        make_frame(ver, kind, len, n_pay, fault);
        send_frame();
    endtask

    // bytes with no frame structure, last set at random
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 30);
        for (int k = 0; k < n; k++)
            push_byte(8'($urandom), (k == n - 1) || ($urandom_range(0, 7) == 0), 1'b0, '0);
    endtask

    task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] g);
        if (e !== g) begin
            if (errors < 40)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, g);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (word_q.size() == 0) begin
                if (errors < 40) $display("%0t: result word with nothing expected", $time);
                errors++;
            end else begin
                want = word_q.pop_front();
                check_field("payload_valid", 32'(want.payload_valid), 32'(o_payload_valid));
                check_field("payload_byte", 32'(want.payload_byte), 32'(o_payload_byte));
                check_field("payload_index", 32'(want.payload_index), 32'(o_payload_index));
                check_field("done_res", 32'(want.done_res), 32'(o_done_res));
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("frame_kind", 32'(want.frame_kind), 32'(o_frame_kind));
                check_field("session_word", want.session_word, o_session_word);
                check_field("sequence_word", want.sequence_word, o_sequence_word);
                check_field("payload_count", 32'(want.payload_count), 32'(o_payload_count));
            end
        end
    end

    // receiver: stall pattern in spans, plus a long hold-off on request
    int stall_pct = 0;
    int span_left = 0;
    int hold_left = 0;
    int hold_seen = 0;

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (hold_seen != hold_ask) begin
            hold_seen <= hold_ask;
            hold_left <= HOLD_CYCLES;
            i_stall   <= 1'b1;
        end else begin
            if (span_left == 0) begin
                span_left <= $urandom_range(8, 64);
                case ($urandom_range(0, 3))
                    0:       stall_pct <= 0;
                    1:       stall_pct <= 20;
                    2:       stall_pct <= 50;
                    default: stall_pct <= 85;
                endcase
            end else begin
                span_left <= span_left - 1;
            end
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial begin
        #8_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        t_row       rows[$];
        t_result    w;
        int         start;
        logic [7:0] tmin, tmax, ver, maxp;

        lim_type_lo  = 8'h00;
        lim_type_hi  = 8'hFF;
        want_version = 8'h01;
        pay_limit    = 8'hFF;
        clear_frame_state();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // one-byte frames straight after reset: length error, all fields zero; then a frame with a bad magic byte
        w = '0;
        w.done_res = 1'b1;
        w.status   = ST_LEN;
        rows.push_back('{8'hFF, 1'b1, 1'b1, w});
        rows.push_back('{8'h00, 1'b1, 1'b1, w});
        for (int k = 0; k < 19; k++)
            rows.push_back('{BAD_MAGIC_FRAME[8*(18-k) +: 8], k == 18, 1'b0, '0});
        w.status        = ST_HDR;
        w.frame_kind    = 8'h07;
        w.session_word  = 32'hDEAD_BEEF;
        w.sequence_word = 32'h0102_0304;
        rows[rows.size()-1].typed = 1'b1;
        rows[rows.size()-1].want  = w;
        foreach (rows[k]) push_byte(rows[k].data, rows[k].last, rows[k].typed, rows[k].want);

        // hand-built frames at the reset settings
        set_config(8'h00, 8'hFF, 8'h01, 8'hFF, 1'b1);
        make_frame(8'h01, 8'h00, 8'h00, 0, FF_NONE);   send_frame();
        make_frame(8'h01, 8'hFF, 8'h03, 3, FF_NONE);   send_frame();
        make_frame(8'h01, 8'h11, 8'h04, 4, FF_CRC);    send_frame();
        make_frame(8'h01, 8'h11, 8'h04, 4, FF_MAGIC);  send_frame();
        make_frame(8'h02, 8'h11, 8'h04, 4, FF_NONE);   send_frame();
        make_frame(8'h01, 8'h11, 8'h05, 4, FF_NONE);   send_frame();
        make_frame(8'h01, 8'h11, 8'h04, 4, FF_TRUNC);  send_frame();
        make_frame(8'h01, 8'h11, 8'h04, 4, FF_EXTRA);  send_frame();
        // full payload region, then the byte counter saturates before the frame ends
        make_frame(8'h01, 8'h42, 8'hFF, 500, FF_NONE); send_frame();
        send_noise();

        // long receiver hold-off while the sender keeps offering back to back
        idle_on = 1'b0;
        hold_ask <= hold_ask + 1;
        make_frame(8'h01, 8'h20, 8'd40, 40, FF_NONE);  send_frame();
        idle_on = 1'b1;

        // empty type window, version zero, no payload allowed
        set_config(8'h0A, 8'h09, 8'h00, 8'h00, 1'b0);
        make_frame(8'h00, 8'h09, 8'h00, 0, FF_NONE);   send_frame();
        make_frame(8'h00, 8'h0A, 8'h00, 0, FF_NONE);   send_frame();
        // single-type window, version 255
        set_config(8'h80, 8'h80, 8'hFF, 8'h00, 1'b0);
        make_frame(8'hFF, 8'h80, 8'h00, 0, FF_NONE);   send_frame();
        make_frame(8'hFF, 8'h7F, 8'h00, 0, FF_NONE);   send_frame();
        make_frame(8'hFF, 8'h81, 8'h00, 0, FF_NONE);   send_frame();
        // length byte above the limit while the total still fits
        make_frame(8'hFF, 8'h80, 8'h01, 0, FF_NONE);   send_frame();
        make_frame(8'hFF, 8'h80, 8'h01, 1, FF_NONE);   send_frame();
        set_config(8'hFF, 8'hFF, 8'h55, 8'h10, 1'b1);
        make_frame(8'h55, 8'hFF, 8'h10, 16, FF_NONE);  send_frame();
        make_frame(8'h55, 8'hFF, 8'h11, 17, FF_NONE);  send_frame();

        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            case ($urandom_range(0, 4))
                0: begin tmin = 8'h00; tmax = 8'hFF; end
                1: begin
                    tmin = 8'($urandom);
                    tmax = 8'($urandom);
                    if (tmin > tmax) begin
                        ver  = tmin;
                        tmin = tmax;
                        tmax = ver;
                    end
                end
                2: begin tmin = 8'($urandom); tmax = tmin; end
                3: begin tmin = 8'($urandom_range(1, 255)); tmax = tmin - 8'd1; end
                default: begin tmin = 8'h00; tmax = 8'($urandom); end
            endcase
            case ($urandom_range(0, 3))
                0:       ver = 8'h00;
                1:       ver = 8'h01;
                2:       ver = 8'hFF;
                default: ver = 8'($urandom);
            endcase
            case ($urandom_range(0, 3))
                0:       maxp = 8'hFF;
                1:       maxp = 8'h00;
                2:       maxp = 8'($urandom_range(1, 20));
                default: maxp = 8'($urandom);
            endcase
            set_config(tmin, tmax, ver, maxp, $urandom_range(0, 3) == 0);
            idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 6)) begin
                if ($urandom_range(0, 9) == 0) send_noise();
                else random_frame();
            end
        end

        i_valid <= 1'b0;
        while (word_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
design/ofd_pkg.sv
design/ofd_out_reg.sv
design/ota_frame_deframer_crc32_top.sv
test/testbench.sv
